// ===== rtl/dema_pkg.sv =====
// ----------------------------------------------------------------------------
// dema_pkg
// shared constants and register indexes for the dual average touch detector
// ----------------------------------------------------------------------------
`default_nettype none

package dema_pkg;

  // gains are unsigned Q0.16
  localparam int GAIN_BITS = 16;

  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SLOW_GAIN         = 2'd0,
    REG_FAST_GAIN         = 2'd1,
    REG_TRIGGER_THRESHOLD = 2'd2,
    REG_SAMPLE_LIMIT      = 2'd3
  } cfg_reg_t;

  localparam logic [GAIN_BITS-1:0] SLOW_GAIN_RESET = 16'd524;
  localparam logic [GAIN_BITS-1:0] FAST_GAIN_RESET = 16'd13107;
  localparam logic [31:0]          THRESHOLD_RESET = 32'd10000;
  localparam logic [31:0]          LIMIT_RESET     = 32'd40000000;

  localparam int TIME_BITS = 32;

endpackage

`default_nettype wire

// ===== rtl/dema_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dema_cfg_regs
// configuration register file: gains, trigger threshold and sample limit
// ----------------------------------------------------------------------------
`default_nettype none

module dema_cfg_regs #(
  parameter int SAMPLE_BITS = 28,
  parameter int CFG_BITS    = 28
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dema_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [CFG_BITS-1:0]                   cfg_data,
  output logic [dema_pkg::GAIN_BITS-1:0]        slow_gain,
  output logic [dema_pkg::GAIN_BITS-1:0]        fast_gain,
  output logic [SAMPLE_BITS-1:0]                trigger_threshold,
  output logic [SAMPLE_BITS-1:0]                sample_limit
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_gain         <= dema_pkg::SLOW_GAIN_RESET;
      fast_gain         <= dema_pkg::FAST_GAIN_RESET;
      trigger_threshold <= dema_pkg::THRESHOLD_RESET[SAMPLE_BITS-1:0];
      sample_limit      <= dema_pkg::LIMIT_RESET[SAMPLE_BITS-1:0];
    end else if (cfg_valid) begin
      case (dema_pkg::cfg_reg_t'(cfg_index))
        dema_pkg::REG_SLOW_GAIN:         slow_gain <= cfg_data[dema_pkg::GAIN_BITS-1:0];
        dema_pkg::REG_FAST_GAIN:         fast_gain <= cfg_data[dema_pkg::GAIN_BITS-1:0];
        dema_pkg::REG_TRIGGER_THRESHOLD: trigger_threshold <= cfg_data[SAMPLE_BITS-1:0];
        dema_pkg::REG_SAMPLE_LIMIT:      sample_limit <= cfg_data[SAMPLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dema_ema.sv =====
// ----------------------------------------------------------------------------
// dema_ema
// one exponential average: holds the average and works out its next value
// ----------------------------------------------------------------------------
`default_nettype none

module dema_ema #(
  parameter int SAMPLE_BITS   = 28,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        update,
  input  logic [SAMPLE_BITS-1:0]                      sample,
  input  logic [dema_pkg::GAIN_BITS-1:0]              gain,
  output logic [SAMPLE_BITS+FRACTION_BITS-1:0]        average_next
);

  localparam int AVG_BITS  = SAMPLE_BITS + FRACTION_BITS;
  localparam int PROD_BITS = AVG_BITS + dema_pkg::GAIN_BITS + 2;

  logic [AVG_BITS-1:0]          average;
  logic [AVG_BITS-1:0]          sample_big;
  logic signed [AVG_BITS:0]     delta;
  logic signed [PROD_BITS-1:0]  product;
  logic signed [AVG_BITS+1:0]   step;
  logic signed [AVG_BITS+1:0]   sum;
  logic [AVG_BITS-1:0]          blended;

  // avg + floor(g * (X - avg) / 2^16) approximates the weighted blend, truncated
  always_comb begin
    sample_big = {sample, {FRACTION_BITS{1'b0}}};
    delta      = $signed({1'b0, sample_big}) - $signed({1'b0, average});
    product    = delta * $signed({1'b0, gain});
    step       = product[PROD_BITS-1:dema_pkg::GAIN_BITS];
    sum        = $signed({2'b00, average}) + step;
    blended    = sum[AVG_BITS-1:0];
    if (!update) begin
      average_next = average;
    end else if (average == '0) begin
      // seed with the first nonzero sample
      average_next = sample_big;
    end else begin
      average_next = blended;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average <= '0;
    end else begin
      average <= average_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dual_ema_touch_detector_core.sv =====
// ----------------------------------------------------------------------------
// dual_ema_touch_detector_core
// slow and fast averages of capacitance samples with touch / release events
// ----------------------------------------------------------------------------
// a request passes the input register, then the result register, on its way to the result
// throughput: one request per cycle while the output is not stalled; both averages update in one registered step
// reset (rst, synchronous): averages and held reading cleared, minimum all ones,
// maximum zero, released, registers back to their defaults
`default_nettype none

module dual_ema_touch_detector_core #(
  parameter int SAMPLE_BITS   = 28,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // sample, time_ms
  input  logic [((SAMPLE_BITS+dema_pkg::TIME_BITS+7)/8)*8-1:0]   s_tdata,
  // in_time
  input  logic [0:0]                             s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // reading_held, event_difference, event_time, min_reading, max_reading
  output logic [((4*SAMPLE_BITS+dema_pkg::TIME_BITS+7)/8)*8-1:0] m_tdata,
  // event_valid, event_touch
  output logic [1:0]                             m_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dema_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16)-1:0] cfg_data
);

  localparam int SB       = SAMPLE_BITS;
  localparam int TB       = dema_pkg::TIME_BITS;
  localparam int AVG_BITS = SAMPLE_BITS + FRACTION_BITS;
  localparam int CFG_BITS = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

  logic [dema_pkg::GAIN_BITS-1:0] slow_gain;
  logic [dema_pkg::GAIN_BITS-1:0] fast_gain;
  logic [SB-1:0]                  trigger_threshold;
  logic [SB-1:0]                  sample_limit;

  dema_cfg_regs #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CFG_BITS    (CFG_BITS)
  ) u_cfg (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .slow_gain         (slow_gain),
    .fast_gain         (fast_gain),
    .trigger_threshold (trigger_threshold),
    .sample_limit      (sample_limit)
  );

  // input register
  logic          in_valid;
  logic [SB-1:0] in_sample;
  logic          in_on_time;
  logic [TB-1:0] in_time_ms;
  logic          advance;
  logic          step;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample  <= s_tdata[SB-1:0];
      in_time_ms <= s_tdata[SB+TB-1:SB];
      in_on_time <= s_tuser[0];
    end
  end

  logic accepted;
  logic avg_update;
  assign accepted   = step && in_on_time && (in_sample < sample_limit);
  assign avg_update = accepted && (in_sample != '0);

  logic [AVG_BITS-1:0] slow_next;
  logic [AVG_BITS-1:0] fast_next;

  dema_ema #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_slow (
    .clk          (clk),
    .rst          (rst),
    .update       (avg_update),
    .sample       (in_sample),
    .gain         (slow_gain),
    .average_next (slow_next)
  );

  dema_ema #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_fast (
    .clk          (clk),
    .rst          (rst),
    .update       (avg_update),
    .sample       (in_sample),
    .gain         (fast_gain),
    .average_next (fast_next)
  );

  // touch decision on the freshly updated averages
  logic                positive;
  logic [AVG_BITS-1:0] magnitude;
  logic [AVG_BITS-1:0] threshold_big;
  logic                touch;
  logic                touch_next;
  logic                event_fire;

  always_comb begin
    positive      = slow_next >= fast_next;
    magnitude     = positive ? slow_next - fast_next : fast_next - slow_next;
    threshold_big = {trigger_threshold, {FRACTION_BITS{1'b0}}};
    touch_next    = touch;
    event_fire    = 1'b0;
    if (accepted) begin
      if (!touch && magnitude < threshold_big) begin
        touch_next = 1'b1;
        event_fire = 1'b1;
      end else if (touch && positive && magnitude > threshold_big) begin
        touch_next = 1'b0;
        event_fire = 1'b1;
      end
    end
  end

  // held reading, min, max and touch state double as the result fields:
  // they only move when a result is loaded
  logic          ev_valid;
  logic [SB-1:0] ev_difference;
  logic [TB-1:0] ev_time;
  logic [SB-1:0] held_reading;
  logic [SB-1:0] running_min;
  logic [SB-1:0] running_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_reading <= '0;
      running_min  <= '1;
      running_max  <= '0;
      touch        <= 1'b0;
    end else begin
      touch <= touch_next;
      if (accepted) begin
        held_reading <= in_sample;
        if (in_sample < running_min) begin
          running_min <= in_sample;
        end
        if (in_sample > running_max) begin
          running_max <= in_sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ev_valid      <= event_fire;
      ev_difference <= event_fire ? magnitude[AVG_BITS-1:FRACTION_BITS] : '0;
      ev_time       <= event_fire ? in_time_ms : '0;
    end
  end

  always_comb begin
    m_tdata                             = '0;
    m_tdata[SB-1:0]                     = held_reading;
    m_tdata[2*SB-1:SB]                  = ev_difference;
    m_tdata[2*SB+TB-1:2*SB]             = ev_time;
    m_tdata[3*SB+TB-1:2*SB+TB]          = running_min;
    m_tdata[4*SB+TB-1:3*SB+TB]          = running_max;
    m_tuser                             = {touch, ev_valid};
  end

endmodule

`default_nettype wire
